### hw/rtl/min_priority_queue_defines.svh
// Assertion macros for the min priority queue.
`ifndef MIN_PRIORITY_QUEUE_DEFINES_SVH
`define MIN_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
`define MPQ_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define MPQ_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MPQ_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define MPQ_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

### hw/rtl/mpq_pkg.sv
// Types and constants shared by the min priority queue.
package mpq_pkg;

	localparam int HEAP_DEPTH = 128;
	localparam int KEY_BITS   = 16;
	localparam int CELL_W     = 8;
	localparam int KEY_FIELD_W = 16;
	localparam int COUNT_FIELD_W = 8;

	localparam int ADDR_W    = $clog2(HEAP_DEPTH);
	localparam int MEM_DEPTH = 1 << ADDR_W;
	localparam int CNT_W     = $clog2(HEAP_DEPTH + 1);
	localparam int IDX_W     = CNT_W + 1;

	typedef enum logic [1:0] {
		MODE_PUSH   = 2'd0,
		MODE_POP    = 2'd1,
		MODE_UPDATE = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP_RD,
		S_SRCH,
		S_UP_START,
		S_UP,
		S_DOWN,
		S_PLACE,
		S_DONE
	} seq_state_t;

	typedef struct packed {
		mode_t                  mode;
		logic [CELL_W-1:0]      cell_id;
		logic [KEY_FIELD_W-1:0] key_value;
	} cmd_t;

	typedef struct packed {
		logic [CELL_W-1:0]        popped_cell;
		logic [COUNT_FIELD_W-1:0] entry_count;
		status_t                  status;
	} rsp_t;

	typedef struct packed {
		logic [CELL_W-1:0]   cell_id;
		logic [KEY_BITS-1:0] key;
	} entry_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		entry_t            wdata;
		logic [ADDR_W-1:0] raddr_a;
		logic [ADDR_W-1:0] raddr_b;
	} mem_req_t;

endpackage

### hw/rtl/min_priority_queue.sv
// Top level of the min priority queue: sequencer, heap store and result register.
//
//  channel | direction | handshake             | payload
//  cmd     | in        | cmd_valid / cmd_ready | mode, cell_id, key_value
//  rsp     | out       | rsp_valid / rsp_ready | popped_cell, entry_count, status
//
// One item at a time; cmd_ready is low from acceptance until its result is handed on.
// Update: a two-slot-per-cycle search before the climb.
// Sift speed is set by the single heap store: one level per cycle.
// Reset clears the count and sequencer; heap slots are not cleared.
// A finished result waits in the output register while the next item is taken.
`include "min_priority_queue_defines.svh"

module min_priority_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  mpq_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output mpq_pkg::rsp_t rsp
);
	import mpq_pkg::*;

	mem_req_t mem_req;
	entry_t   rd_a, rd_b;
	rsp_t     res, rsp_q;
	logic     res_valid, res_ready, rsp_valid_q;

	logic [COUNT_FIELD_W-1:0] depth_cnt;
	logic                     full_rsp, empty_rsp, empty_clean;

	mpq_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_req   (mem_req),
		.rd_a      (rd_a),
		.rd_b      (rd_b)
	);

	mpq_store u_store (
		.clk  (clk),
		.req  (mem_req),
		.rd_a (rd_a),
		.rd_b (rd_b)
	);

	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign depth_cnt   = COUNT_FIELD_W'(HEAP_DEPTH);
	assign full_rsp    = rsp_valid && (rsp.status == ST_FULL);
	assign empty_rsp   = rsp_valid && (rsp.status == ST_EMPTY);
	assign empty_clean = (rsp.entry_count == '0) && (rsp.popped_cell == '0);

	`MPQ_ASSERT_IMP(a_count_bound, clk, arst_n, rsp_valid, rsp.entry_count <= depth_cnt, "count over depth")
	`MPQ_ASSERT_IMP(a_full_count, clk, arst_n, full_rsp, rsp.entry_count == depth_cnt, "bad full status")
	`MPQ_ASSERT_IMP(a_empty_pop, clk, arst_n, empty_rsp, empty_clean, "bad empty status")
	`MPQ_ASSERT_NXT(a_busy_after_cmd, clk, arst_n, cmd_valid && cmd_ready, !cmd_ready, "ready after accept")

endmodule

### hw/rtl/mpq_store.sv
// Heap storage: one write port, two registered read ports.
module mpq_store (
	input  logic              clk,
	input  mpq_pkg::mem_req_t req,
	output mpq_pkg::entry_t   rd_a,
	output mpq_pkg::entry_t   rd_b
);
	import mpq_pkg::*;

	entry_t mem_q [MEM_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rd_a <= mem_q[req.raddr_a];
		rd_b <= mem_q[req.raddr_b];
	end

endmodule

### hw/rtl/mpq_seq.sv
// Command sequencer: search, sift up and sift down over the shared heap store.
module mpq_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  mpq_pkg::cmd_t     cmd,
	output logic              res_valid,
	input  logic              res_ready,
	output mpq_pkg::rsp_t     res,
	output mpq_pkg::mem_req_t mem_req,
	input  mpq_pkg::entry_t   rd_a,
	input  mpq_pkg::entry_t   rd_b
);
	import mpq_pkg::*;

	seq_state_t        state_q, state_d;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  pos_q, sidx_q;
	entry_t            mov_q;
	logic [CELL_W-1:0] popped_q;
	status_t           status_q;

	logic [IDX_W-1:0] cnt_x, par_idx, gpar_idx, lo_idx, hi_idx, pick_idx, nlo_idx, nhi_idx;
	logic [IDX_W-1:0] last_idx, s1_idx, s2_idx, s3_idx;
	logic [CNT_W-1:0] dec_cnt;
	entry_t           pick_ent;
	logic             accept, is_full, is_empty, up_less, down_less, hit_a, hit_b, more;

	// moving entry stays in mov_q; the hole walks through the heap
	always_comb begin
		cnt_x    = IDX_W'(count_q);
		par_idx  = (pos_q - IDX_W'(1)) >> 1;
		gpar_idx = (par_idx - IDX_W'(1)) >> 1;
		lo_idx   = {pos_q[IDX_W-2:0], 1'b1};
		hi_idx   = lo_idx + IDX_W'(1);
		// ties between children go right
		if ((hi_idx >= cnt_x) || (rd_a.key < rd_b.key)) begin
			pick_idx = lo_idx;
			pick_ent = rd_a;
		end else begin
			pick_idx = hi_idx;
			pick_ent = rd_b;
		end
		nlo_idx   = {pick_idx[IDX_W-2:0], 1'b1};
		nhi_idx   = nlo_idx + IDX_W'(1);
		dec_cnt   = count_q - CNT_W'(1);
		last_idx  = IDX_W'(dec_cnt);
		s1_idx    = sidx_q + IDX_W'(1);
		s2_idx    = sidx_q + IDX_W'(2);
		s3_idx    = sidx_q + IDX_W'(3);
		up_less   = mov_q.key < rd_a.key;
		down_less = pick_ent.key < mov_q.key;
		hit_a     = rd_a.cell_id == mov_q.cell_id;
		hit_b     = (s1_idx < cnt_x) && (rd_b.cell_id == mov_q.cell_id);
		more      = s2_idx < cnt_x;
		is_full   = count_q >= CNT_W'(HEAP_DEPTH);
		is_empty  = count_q == '0;
		accept    = cmd_valid && cmd_ready;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (cmd.mode)
						MODE_PUSH:   state_d = is_full ? S_DONE : S_UP_START;
						MODE_POP:    state_d = is_empty ? S_DONE : S_POP_RD;
						MODE_UPDATE: state_d = is_empty ? S_DONE : S_SRCH;
						MODE_CLEAR:  state_d = S_DONE;
						default:     state_d = S_DONE;
					endcase
				end
			end
			S_POP_RD:   state_d = (dec_cnt > CNT_W'(1)) ? S_DOWN : S_DONE;
			S_SRCH:     state_d = (hit_a || hit_b) ? S_UP_START : (more ? S_SRCH : S_DONE);
			S_UP_START: state_d = (pos_q == '0) ? S_DONE : S_UP;
			S_UP:       state_d = up_less ? ((par_idx == '0) ? S_PLACE : S_UP) : S_DONE;
			S_DOWN:     state_d = down_less ? ((nlo_idx < cnt_x) ? S_DOWN : S_PLACE) : S_DONE;
			S_PLACE:    state_d = S_DONE;
			S_DONE:     state_d = res_ready ? S_IDLE : S_DONE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		mem_req   = '0;
		cmd_ready = (state_q == S_IDLE);
		res_valid = (state_q == S_DONE);
		unique case (state_q)
			S_IDLE: begin
				mem_req.raddr_a = '0;
				mem_req.raddr_b = (cmd.mode == MODE_POP) ? last_idx[ADDR_W-1:0] : ADDR_W'(1);
			end
			S_POP_RD: begin
				// one entry left (or none): last entry lands at the root directly
				mem_req.we      = !(dec_cnt > CNT_W'(1));
				mem_req.waddr   = '0;
				mem_req.wdata   = rd_b;
				mem_req.raddr_a = ADDR_W'(1);
				mem_req.raddr_b = ADDR_W'(2);
			end
			S_SRCH: begin
				mem_req.raddr_a = s2_idx[ADDR_W-1:0];
				mem_req.raddr_b = s3_idx[ADDR_W-1:0];
			end
			S_UP_START: begin
				mem_req.we      = (pos_q == '0);
				mem_req.waddr   = pos_q[ADDR_W-1:0];
				mem_req.wdata   = mov_q;
				mem_req.raddr_a = par_idx[ADDR_W-1:0];
			end
			S_UP: begin
				mem_req.we      = 1'b1;
				mem_req.waddr   = pos_q[ADDR_W-1:0];
				mem_req.wdata   = up_less ? rd_a : mov_q;
				mem_req.raddr_a = gpar_idx[ADDR_W-1:0];
			end
			S_DOWN: begin
				mem_req.we      = 1'b1;
				mem_req.waddr   = pos_q[ADDR_W-1:0];
				mem_req.wdata   = down_less ? pick_ent : mov_q;
				mem_req.raddr_a = nlo_idx[ADDR_W-1:0];
				mem_req.raddr_b = nhi_idx[ADDR_W-1:0];
			end
			S_PLACE: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = pos_q[ADDR_W-1:0];
				mem_req.wdata = mov_q;
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && accept) begin
				if (cmd.mode == MODE_PUSH && !is_full) begin
					count_q <= count_q + CNT_W'(1);
				end else if (cmd.mode == MODE_CLEAR) begin
					count_q <= '0;
				end
			end else if (state_q == S_POP_RD) begin
				count_q <= dec_cnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					mov_q.cell_id <= cmd.cell_id;
					mov_q.key     <= cmd.key_value[KEY_BITS-1:0];
					pos_q         <= cnt_x;
					sidx_q        <= '0;
					popped_q      <= '0;
					if (cmd.mode == MODE_PUSH && is_full) begin
						status_q <= ST_FULL;
					end else if (cmd.mode == MODE_POP && is_empty) begin
						status_q <= ST_EMPTY;
					end else if (cmd.mode == MODE_UPDATE && is_empty) begin
						status_q <= ST_MISSING;
					end else begin
						status_q <= ST_OK;
					end
				end
			end
			S_POP_RD: begin
				popped_q <= rd_a.cell_id;
				mov_q    <= rd_b;
				pos_q    <= '0;
			end
			S_SRCH: begin
				if (hit_a) begin
					pos_q <= sidx_q;
				end else if (hit_b) begin
					pos_q <= s1_idx;
				end else if (more) begin
					sidx_q <= s2_idx;
				end else begin
					status_q <= ST_MISSING;
				end
			end
			S_UP: begin
				if (up_less) begin
					pos_q <= par_idx;
				end
			end
			S_DOWN: begin
				if (down_less) begin
					pos_q <= pick_idx;
				end
			end
			default: begin
			end
		endcase
	end

	assign res.popped_cell = popped_q;
	assign res.entry_count = COUNT_FIELD_W'(count_q);
	assign res.status      = status_q;

endmodule
